[hdl/emg_pulse_gesture_classifier_assert.svh]
// Assertion macros shared by the EMG pulse gesture classifier RTL
`ifndef EMG_PULSE_GESTURE_CLASSIFIER_ASSERT_SVH
`define EMG_PULSE_GESTURE_CLASSIFIER_ASSERT_SVH
`ifndef SYNTHESIS
// Check a property on every clock edge outside reset
`define EMGC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
// Check that a condition is followed in the next cycle by a consequence
`define EMGC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define EMGC_ASSERT(lbl, prop, msg)
`define EMGC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

[hdl/emgc_pkg.sv]
// Types and constants of the EMG pulse gesture classifier
package emgc_pkg;

    localparam int CHANNELS  = 4;
    localparam int CHAN_W    = 2;
    localparam int SAMPLE_W  = 12;
    localparam int Q_W       = 20;
    localparam int TIME_W    = 32;
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 3;
    localparam int DIV_NUM_W = 29;
    localparam int DIV_DEN_W = 21;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_ENV_ALPHA   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_THR    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_PULSE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SILENCE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_CUTOFF  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_UPD_PERIOD  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ROLL_WINDOW = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_ADC_MID     = 3'd7;

    // reset values
    localparam logic [15:0] RST_ENV_ALPHA   = 16'd3277;
    localparam logic [11:0] RST_BASE_THR    = 12'd1800;
    localparam logic [15:0] RST_MIN_PULSE   = 16'd30;
    localparam logic [15:0] RST_SILENCE     = 16'd400;
    localparam logic [6:0]  RST_LOW_CUTOFF  = 7'd70;
    localparam logic [23:0] RST_UPD_PERIOD  = 24'd60000;
    localparam logic [7:0]  RST_ROLL_WINDOW = 8'd7;
    localparam logic [11:0] RST_ADC_MID     = 12'd2048;
    localparam logic [Q_W-1:0] RST_AVG      = 20'(2000 * 256);

    localparam logic [6:0] CONF_MAX = 7'd100;

    // divide by ten as multiply by ceil(2^27 / 10) and shift; exact below 2^26
    localparam logic [23:0] RECIP_10    = 24'd13421773;
    localparam int          RECIP_10_SH = 27;

    // one buffered gesture report
    typedef struct packed {
        logic [CHAN_W-1:0] chan;
        logic [1:0]        gest;
        logic [6:0]        conf;
        logic              low;
    } res_t;

endpackage

[hdl/emg_pulse_gesture_classifier.sv]
// Top level of the EMG pulse gesture classifier: sequencer, channel state, result buffer
//
// Usage:
//  - Input requests on s_tvalid/s_tready carry four 12-bit ADC samples and a
//    32-bit millisecond timestamp in s_tdata; s_tuser carries the motion flag.
//    A request with motion set is taken at once and changes nothing.
//  - Gesture reports leave on m_tvalid/m_tready, one per reporting channel in
//    channel order; m_tlast marks the last report caused by a sample.
//  - Configuration registers are written through cfg_wr_en/cfg_index/cfg_data;
//    the user must write them only while the block is idle, which the block itself
//    does not enforce; writing the base threshold reloads every channel's threshold.
//  - Sequence: each channel passes through rectify and scale, envelope accumulate
//    and pulse logic. A channel that reports then forms its confidence on the
//    radix-2 divider, unless its threshold is zero or its peak is weak; an
//    adaptation pass runs each channel's average through the divider, plus a
//    reciprocal multiply by 1/10 where the threshold moves.
//  - s_tready is high only while the sequencer is idle; reports are held in a
//    buffer and stay on the master side for as long as m_tready is low, and
//    no new sample is taken until the last one has gone.
//  - aresetn is synchronous, active low; it restores register defaults, clears
//    channel state and loads every threshold from the base threshold.
`include "emg_pulse_gesture_classifier_assert.svh"
module emg_pulse_gesture_classifier
    import emgc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // sample_ch0, sample_ch1, sample_ch2, sample_ch3, sample_time_ms
    input  logic [79:0]          s_tdata,
    // motion_flag
    input  logic [0:0]           s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // channel, gesture, confidence, zero fill
    output logic [15:0]          m_tdata,
    // low_confidence
    output logic [0:0]           m_tuser,
    output logic                 m_tlast,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);
    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_ENV1   = 4'd1;
    localparam logic [3:0] ST_ENV2   = 4'd2;
    localparam logic [3:0] ST_PULSE  = 4'd3;
    localparam logic [3:0] ST_CONF   = 4'd4;
    localparam logic [3:0] ST_CDIV   = 4'd5;
    localparam logic [3:0] ST_ADAPT  = 4'd6;
    localparam logic [3:0] ST_AVG1   = 4'd7;
    localparam logic [3:0] ST_AVGDIV = 4'd8;
    localparam logic [3:0] ST_THRDIV = 4'd9;
    localparam logic [3:0] ST_EMIT   = 4'd10;

    localparam logic [CHAN_W-1:0] LAST_CH = CHAN_W'(CHANNELS - 1);

    logic [3:0]          state_reg;
    logic [CHAN_W-1:0]   ch_reg;
    logic [SAMPLE_W-1:0] smp_reg [CHANNELS];
    logic [TIME_W-1:0]   now_reg;

    // configuration
    logic [15:0] alpha_reg;
    logic [15:0] min_pulse_reg;
    logic [15:0] silence_reg;
    logic [6:0]  cutoff_reg;
    logic [23:0] period_reg;
    logic [7:0]  window_reg;
    logic [11:0] mid_reg;

    // per-channel state
    logic [Q_W-1:0]    env_reg  [CHANNELS];
    logic [Q_W-1:0]    gp_reg   [CHANNELS];
    logic              ip_reg   [CHANNELS];
    logic [TIME_W-1:0] pst_reg  [CHANNELS];
    logic [7:0]        cnt_reg  [CHANNELS];
    logic [TIME_W-1:0] lpt_reg  [CHANNELS];
    logic [Q_W-1:0]    pp_reg   [CHANNELS];
    logic [Q_W-1:0]    avg_reg  [CHANNELS];
    logic [Q_W-1:0]    thr_reg  [CHANNELS];
    logic [TIME_W-1:0] last_upd_reg;

    logic [35:0] prod_reg;

    // result buffer
    res_t              res_reg [CHANNELS];
    logic [CHAN_W:0]   res_cnt_reg;
    logic [CHAN_W-1:0] emit_idx_reg;
    logic [CHAN_W-1:0] res_slot;

    // divider
    logic                 div_start_reg;
    logic [DIV_NUM_W-1:0] div_num_reg;
    logic [DIV_DEN_W-1:0] div_den_reg;
    logic                 div_done;
    logic [DIV_NUM_W-1:0] div_quot;

    // rectify
    logic [SAMPLE_W-1:0] smp_c;
    logic [SAMPLE_W-1:0] mag;
    logic [Q_W-1:0]      rect;

    // envelope accumulate
    logic [16:0]    inv_alpha;
    logic [37:0]    acc;
    logic [Q_W-1:0] env_new;

    // pulse logic
    logic [Q_W-1:0]    env_c, thr_c, gp_c, pp_c;
    logic [Q_W-1:0]    gp_next, pp_next;
    logic              ip_next;
    logic [TIME_W-1:0] pst_next, lpt_next;
    logic [7:0]        cnt_next;
    logic              rep_next;
    logic [1:0]        gest_next;
    logic [TIME_W-1:0] pulse_len, quiet_len;

    // confidence
    logic [26:0] p100;
    logic [26:0] t40;
    logic [27:0] t_low;
    logic        low_c;
    logic [DIV_NUM_W-1:0] conf_num;

    // adaptation
    logic [7:0]           w_eff;
    logic [DIV_NUM_W-1:0] avg_sum;
    logic [Q_W-1:0]       avg_new;
    logic                 thr_upd;
    logic [TIME_W-1:0]    upd_len;
    logic [52:0]          thr_prod;
    logic [Q_W-1:0]       thr_scaled;

    emgc_div #(
        .NUM_W (DIV_NUM_W),
        .DEN_W (DIV_DEN_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start_reg),
        .num     (div_num_reg),
        .den     (div_den_reg),
        .done    (div_done),
        .quot    (div_quot)
    );

    assign res_slot = res_cnt_reg[CHAN_W-1:0];

    // rectify about the midpoint and scale to Q12.8
    always_comb begin
        smp_c = smp_reg[ch_reg];
        mag   = (smp_c >= mid_reg) ? (smp_c - mid_reg) : (mid_reg - smp_c);
        rect  = {mag, 8'd0};
    end

    // envelope: weighted blend of new magnitude and held level, rounded
    always_comb begin
        inv_alpha = 17'h10000 - {1'b0, alpha_reg};
        acc       = 38'(prod_reg) + 38'(inv_alpha) * 38'(env_reg[ch_reg]) + 38'd32768;
        env_new   = acc[35:16];
    end

    // pulse detection, length check, silence check
    always_comb begin
        env_c = env_reg[ch_reg];
        thr_c = thr_reg[ch_reg];
        gp_c  = gp_reg[ch_reg];
        pp_c  = pp_reg[ch_reg];

        gp_next  = (env_c > gp_c) ? env_c : gp_c;
        ip_next  = ip_reg[ch_reg];
        pst_next = pst_reg[ch_reg];
        cnt_next = cnt_reg[ch_reg];
        lpt_next = lpt_reg[ch_reg];
        pp_next  = pp_c;

        if (!ip_next && env_c > thr_c) begin
            ip_next  = 1'b1;
            pst_next = now_reg;
            gp_next  = env_c;
        end

        pulse_len = now_reg - pst_next;
        if (ip_next && (23'(env_c) * 23'd5 < 23'(thr_c) * 23'd3)) begin
            ip_next = 1'b0;
            if (pulse_len >= 32'(min_pulse_reg)) begin
                if (cnt_next != 8'd255) begin
                    cnt_next = cnt_next + 8'd1;
                end
                lpt_next = now_reg;
                if (gp_next > pp_next) begin
                    pp_next = gp_next;
                end
            end
        end

        quiet_len = now_reg - lpt_next;
        rep_next  = !ip_next && (cnt_next != 8'd0) && (quiet_len > 32'(silence_reg));
        gest_next = (cnt_next >= 8'd4) ? 2'd3 : cnt_next[1:0] - 2'd1;
    end

    // confidence operands and the low-confidence flag
    always_comb begin
        p100  = 27'(gp_reg[ch_reg]) * 27'd100;
        t40   = 27'(thr_reg[ch_reg]) * 27'd40;
        t_low = 28'(thr_reg[ch_reg]) * (28'd40 + 28'(cutoff_reg));
        if (cutoff_reg > CONF_MAX) begin
            low_c = 1'b1;
        end else if (cutoff_reg == 7'd0 || thr_reg[ch_reg] == '0) begin
            low_c = 1'b0;
        end else begin
            low_c = 28'(p100) < t_low;
        end
        conf_num = DIV_NUM_W'({p100 - t40, 1'b0}) + DIV_NUM_W'(thr_reg[ch_reg]);
    end

    // rolling average and threshold update operands
    always_comb begin
        w_eff      = (window_reg == 8'd0) ? 8'd1 : window_reg;
        avg_sum    = DIV_NUM_W'(avg_reg[ch_reg]) * DIV_NUM_W'(w_eff - 8'd1)
                   + DIV_NUM_W'(pp_reg[ch_reg]) + DIV_NUM_W'(w_eff[7:1]);
        avg_new    = div_quot[Q_W-1:0];
        thr_upd    = 23'(pp_reg[ch_reg]) * 23'd5 > 23'(avg_new) * 23'd4;
        upd_len    = now_reg - last_upd_reg;
        thr_prod   = 53'(div_num_reg) * 53'(RECIP_10);
        thr_scaled = thr_prod[RECIP_10_SH +: Q_W];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            ch_reg        <= '0;
            res_cnt_reg   <= '0;
            emit_idx_reg  <= '0;
            div_start_reg <= 1'b0;
            alpha_reg     <= RST_ENV_ALPHA;
            min_pulse_reg <= RST_MIN_PULSE;
            silence_reg   <= RST_SILENCE;
            cutoff_reg    <= RST_LOW_CUTOFF;
            period_reg    <= RST_UPD_PERIOD;
            window_reg    <= RST_ROLL_WINDOW;
            mid_reg       <= RST_ADC_MID;
            last_upd_reg  <= '0;
            for (int i = 0; i < CHANNELS; i++) begin
                env_reg[i] <= '0;
                gp_reg[i]  <= '0;
                ip_reg[i]  <= 1'b0;
                pst_reg[i] <= '0;
                cnt_reg[i] <= '0;
                lpt_reg[i] <= '0;
                pp_reg[i]  <= '0;
                avg_reg[i] <= RST_AVG;
                thr_reg[i] <= {RST_BASE_THR, 8'd0};
            end
        end else begin
            div_start_reg <= 1'b0;

            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_ENV_ALPHA:   alpha_reg     <= cfg_data[15:0];
                    CFG_BASE_THR: begin
                        for (int i = 0; i < CHANNELS; i++) begin
                            thr_reg[i] <= {cfg_data[11:0], 8'd0};
                        end
                    end
                    CFG_MIN_PULSE:   min_pulse_reg <= cfg_data[15:0];
                    CFG_SILENCE:     silence_reg   <= cfg_data[15:0];
                    CFG_LOW_CUTOFF:  cutoff_reg    <= cfg_data[6:0];
                    CFG_UPD_PERIOD:  period_reg    <= cfg_data[23:0];
                    CFG_ROLL_WINDOW: window_reg    <= cfg_data[7:0];
                    CFG_ADC_MID:     mid_reg       <= cfg_data[11:0];
                    default: ;
                endcase
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        // latch the request; drop it at once when motion is flagged
                        for (int i = 0; i < CHANNELS; i++) begin
                            smp_reg[i] <= s_tdata[i*SAMPLE_W +: SAMPLE_W];
                        end
                        now_reg     <= s_tdata[CHANNELS*SAMPLE_W +: TIME_W];
                        ch_reg      <= '0;
                        res_cnt_reg <= '0;
                        if (!s_tuser[0]) begin
                            state_reg <= ST_ENV1;
                        end
                    end
                end
                ST_ENV1: begin
                    prod_reg  <= 36'(alpha_reg) * 36'(rect);
                    state_reg <= ST_ENV2;
                end
                ST_ENV2: begin
                    env_reg[ch_reg] <= env_new;
                    state_reg       <= ST_PULSE;
                end
                ST_PULSE: begin
                    gp_reg[ch_reg]  <= gp_next;
                    ip_reg[ch_reg]  <= ip_next;
                    pst_reg[ch_reg] <= pst_next;
                    lpt_reg[ch_reg] <= lpt_next;
                    pp_reg[ch_reg]  <= pp_next;
                    if (rep_next) begin
                        cnt_reg[ch_reg]        <= '0;
                        res_reg[res_slot].chan <= ch_reg;
                        res_reg[res_slot].gest <= gest_next;
                        state_reg              <= ST_CONF;
                    end else begin
                        cnt_reg[ch_reg] <= cnt_next;
                        if (ch_reg == LAST_CH) begin
                            state_reg <= ST_ADAPT;
                        end else begin
                            ch_reg    <= ch_reg + 1'b1;
                            state_reg <= ST_ENV1;
                        end
                    end
                end
                ST_CONF: begin
                    res_reg[res_slot].low <= low_c;
                    if (thr_reg[ch_reg] == '0 || p100 < t40) begin
                        // zero threshold gives full confidence, a weak peak none
                        res_reg[res_slot].conf <= (thr_reg[ch_reg] == '0) ? CONF_MAX : 7'd0;
                        res_cnt_reg <= res_cnt_reg + 1'b1;
                        if (ch_reg == LAST_CH) begin
                            state_reg <= ST_ADAPT;
                        end else begin
                            ch_reg    <= ch_reg + 1'b1;
                            state_reg <= ST_ENV1;
                        end
                    end else begin
                        div_num_reg   <= conf_num;
                        div_den_reg   <= {thr_reg[ch_reg], 1'b0};
                        div_start_reg <= 1'b1;
                        state_reg     <= ST_CDIV;
                    end
                end
                ST_CDIV: begin
                    if (div_done) begin
                        res_reg[res_slot].conf <= (div_quot > DIV_NUM_W'(CONF_MAX))
                                                ? CONF_MAX : div_quot[6:0];
                        res_cnt_reg <= res_cnt_reg + 1'b1;
                        if (ch_reg == LAST_CH) begin
                            state_reg <= ST_ADAPT;
                        end else begin
                            ch_reg    <= ch_reg + 1'b1;
                            state_reg <= ST_ENV1;
                        end
                    end
                end
                ST_ADAPT: begin
                    emit_idx_reg <= '0;
                    if (upd_len > 32'(period_reg)) begin
                        last_upd_reg <= now_reg;
                        ch_reg       <= '0;
                        state_reg    <= ST_AVG1;
                    end else begin
                        state_reg <= (res_cnt_reg != '0) ? ST_EMIT : ST_IDLE;
                    end
                end
                ST_AVG1: begin
                    div_num_reg   <= avg_sum;
                    div_den_reg   <= DIV_DEN_W'(w_eff);
                    div_start_reg <= 1'b1;
                    state_reg     <= ST_AVGDIV;
                end
                ST_AVGDIV: begin
                    if (div_done) begin
                        avg_reg[ch_reg] <= avg_new;
                        pp_reg[ch_reg]  <= '0;
                        if (thr_upd) begin
                            // hold nine times the average, rounded, for the divide by ten
                            div_num_reg <= DIV_NUM_W'(avg_new) * DIV_NUM_W'(9)
                                         + DIV_NUM_W'(5);
                            state_reg   <= ST_THRDIV;
                        end else if (ch_reg == LAST_CH) begin
                            state_reg <= (res_cnt_reg != '0) ? ST_EMIT : ST_IDLE;
                        end else begin
                            ch_reg    <= ch_reg + 1'b1;
                            state_reg <= ST_AVG1;
                        end
                    end
                end
                ST_THRDIV: begin
                    thr_reg[ch_reg] <= thr_scaled;
                    if (ch_reg == LAST_CH) begin
                        state_reg <= (res_cnt_reg != '0) ? ST_EMIT : ST_IDLE;
                    end else begin
                        ch_reg    <= ch_reg + 1'b1;
                        state_reg <= ST_AVG1;
                    end
                end
                ST_EMIT: begin
                    // advance through the buffer as each report is taken
                    if (m_tready) begin
                        if (m_tlast) begin
                            res_cnt_reg <= '0;
                            state_reg   <= ST_IDLE;
                        end else begin
                            emit_idx_reg <= emit_idx_reg + 1'b1;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_EMIT);
    assign m_tdata  = {5'd0, res_reg[emit_idx_reg].conf, res_reg[emit_idx_reg].gest,
                       res_reg[emit_idx_reg].chan};
    assign m_tuser  = res_reg[emit_idx_reg].low;
    assign m_tlast  = ({1'b0, emit_idx_reg} == res_cnt_reg - 1'b1);

    `EMGC_ASSERT(a_no_overlap, !(s_tready && m_tvalid), "input taken while reports pending")
    `EMGC_ASSERT_NEXT(a_last_ends, m_tvalid && m_tready && m_tlast, !m_tvalid, "report after last")
    `EMGC_ASSERT(a_conf_range, !m_tvalid || (m_tdata[10:4] <= 7'd100), "confidence out of range")
endmodule

[hdl/emgc_div.sv]
// Shared restoring divider, one quotient bit per cycle
module emgc_div #(
    parameter int NUM_W = 29,
    parameter int DEN_W = 21
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quot
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [DEN_W-1:0] rem_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DEN_W:0]   rem_sh;
    logic [DEN_W:0]   diff;
    logic             ge;

    assign rem_sh = {rem_reg, quo_reg[NUM_W-1]};
    assign ge     = rem_sh >= {1'b0, den};
    assign diff   = rem_sh - {1'b0, den};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                rem_reg  <= '0;
                quo_reg  <= num;
                cnt_reg  <= CNT_W'(NUM_W);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rem_reg <= ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
                quo_reg <= {quo_reg[NUM_W-2:0], ge};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = quo_reg;
endmodule

[bench/tb_top.sv]
// Self-checking testbench for the EMG pulse gesture classifier
`timescale 1ns / 1ps
module tb_top
    import emgc_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 8000;
    localparam int SETTLE_CYCLES  = 400;

    // one expected gesture report
    typedef struct {
        logic [1:0] chan;
        logic [1:0] gest;
        logic [6:0] conf;
        logic       low;
        logic       last;
    } gesture_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    // sample_ch0, sample_ch1, sample_ch2, sample_ch3, sample_time_ms
    logic [79:0]          s_tdata = '0;
    // motion_flag
    logic [0:0]           s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // channel, gesture, confidence, zero fill
    logic [15:0]          m_tdata;
    // low_confidence
    logic [0:0]           m_tuser;
    logic                 m_tlast;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;

    emg_pulse_gesture_classifier uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // predictor copy of the registers
    logic [15:0] alpha_r;
    logic [11:0] base_thr_r;
    logic [15:0] min_pulse_r;
    logic [15:0] silence_r;
    logic [6:0]  cutoff_r;
    logic [23:0] period_r;
    logic [7:0]  window_r;
    logic [11:0] mid_r;

    // predictor copy of the channel state
    logic [19:0] env_q [CHANNELS];
    logic [19:0] gpeak_q [CHANNELS];
    logic        pulsing [CHANNELS];
    logic [31:0] pstart [CHANNELS];
    logic [7:0]  pcount [CHANNELS];
    logic [31:0] plast [CHANNELS];
    logic [19:0] ppeak_q [CHANNELS];
    logic [19:0] avg_q [CHANNELS];
    logic [19:0] thr_q [CHANNELS];
    logic [31:0] last_adapt;

    gesture_t pending_gestures[$];
    int errors = 0;
    int items_sent = 0;
    int gestures_seen = 0;
    logic [31:0] now_ms = '0;
    bit tx_free = 1'b0;
    bit rx_free = 1'b0;

    task automatic report_mismatch(input string what, input int expv, input int gotv);
        $display("mismatch %s: expected %0d got %0d (report %0d)", what, expv, gotv,
                 gestures_seen);
        errors++;
    endtask

    function automatic logic [6:0] conf_of(input logic [19:0] peak, input logic [19:0] thr);
        longint unsigned p100, t40, q;
        p100 = longint'(peak) * 100;
        t40 = longint'(thr) * 40;
        if (thr == 0) return 7'd100;
        if (p100 < t40) return 7'd0;
        q = (2 * (p100 - t40) + thr) / (2 * longint'(thr));
        return q > 100 ? 7'd100 : 7'(q);
    endfunction

    function automatic logic low_of(input logic [19:0] peak, input logic [19:0] thr);
        if (cutoff_r > 100) return 1'b1;
        if (cutoff_r == 0) return 1'b0;
        if (thr == 0) return 1'b0;
        return longint'(peak) * 100 < longint'(thr) * (40 + cutoff_r);
    endfunction

    task automatic reset_predictor();
        alpha_r = RST_ENV_ALPHA;
        base_thr_r = RST_BASE_THR;
        min_pulse_r = RST_MIN_PULSE;
        silence_r = RST_SILENCE;
        cutoff_r = RST_LOW_CUTOFF;
        period_r = RST_UPD_PERIOD;
        window_r = RST_ROLL_WINDOW;
        mid_r = RST_ADC_MID;
        for (int c = 0; c < CHANNELS; c++) begin
            env_q[c] = '0; gpeak_q[c] = '0; pulsing[c] = 1'b0; pstart[c] = '0;
            pcount[c] = '0; plast[c] = '0; ppeak_q[c] = '0; avg_q[c] = RST_AVG;
            thr_q[c] = {base_thr_r, 8'h00};
        end
        last_adapt = '0;
    endtask

    // advance the predicted state by one accepted sample and queue its reports
    task automatic predict_sample(input logic [47:0] smp, input logic [31:0] stamp,
                                  input logic motion);
        logic [11:0] s;
        logic [19:0] r, env, thr, avg;
        longint unsigned acc, w;
        gesture_t g;
        gesture_t batch[$];
        if (motion) return;
        for (int c = 0; c < CHANNELS; c++) begin
            s = smp[c*12 +: 12];
            r = 20'(s >= mid_r ? s - mid_r : mid_r - s) << 8;
            acc = longint'(alpha_r) * r + longint'(65536 - alpha_r) * env_q[c] + 32768;
            env = 20'(acc >> 16);
            thr = thr_q[c];
            env_q[c] = env;
            if (env > gpeak_q[c]) gpeak_q[c] = env;
            if (!pulsing[c] && env > thr) begin
                pulsing[c] = 1'b1;
                pstart[c] = stamp;
                gpeak_q[c] = env;
            end
            if (pulsing[c] && longint'(env) * 5 < longint'(thr) * 3) begin
                pulsing[c] = 1'b0;
                if (32'(stamp - pstart[c]) >= min_pulse_r) begin
                    if (pcount[c] < 255) pcount[c]++;
                    plast[c] = stamp;
                    if (gpeak_q[c] > ppeak_q[c]) ppeak_q[c] = gpeak_q[c];
                end
            end
            if (!pulsing[c] && pcount[c] > 0 && 32'(stamp - plast[c]) > silence_r) begin
                g.chan = 2'(c);
                g.gest = pcount[c] >= 4 ? 2'd3 : 2'(pcount[c] - 1);
                g.conf = conf_of(gpeak_q[c], thr);
                g.low = low_of(gpeak_q[c], thr);
                g.last = 1'b0;
                pcount[c] = '0;
                batch.push_back(g);
            end
        end
        if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
        foreach (batch[i]) pending_gestures.push_back(batch[i]);
        if (32'(stamp - last_adapt) > period_r) begin
            w = window_r == 0 ? 1 : window_r;
            last_adapt = stamp;
            for (int c = 0; c < CHANNELS; c++) begin
                acc = longint'(avg_q[c]) * (w - 1) + ppeak_q[c] + w / 2;
                avg = 20'(acc / w);
                avg_q[c] = avg;
                if (longint'(ppeak_q[c]) * 5 > longint'(avg) * 4)
                    thr_q[c] = 20'((longint'(avg) * 9 + 5) / 10);
                ppeak_q[c] = '0;
            end
        end
    endtask

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (tx_free || roll < 60) return 0;
        if (roll < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // send one sample request and hold it until it is taken
    task automatic send_sample(input logic [47:0] smp, input logic [31:0] stamp,
                               input logic motion);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata <= {stamp, smp};
        s_tuser <= motion;
        do @(posedge aclk); while (!s_tready);
        predict_sample(smp, stamp, motion);
        items_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // hold the sender until every report has come, then let the block settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_gestures.size() > 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [23:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_ENV_ALPHA:   alpha_r = val[15:0];
            CFG_BASE_THR: begin
                base_thr_r = val[11:0];
                for (int c = 0; c < CHANNELS; c++) thr_q[c] = {base_thr_r, 8'h00};
            end
            CFG_MIN_PULSE:   min_pulse_r = val[15:0];
            CFG_SILENCE:     silence_r = val[15:0];
            CFG_LOW_CUTOFF:  cutoff_r = val[6:0];
            CFG_UPD_PERIOD:  period_r = val;
            CFG_ROLL_WINDOW: window_r = val[7:0];
            CFG_ADC_MID:     mid_r = val[11:0];
            default: ;
        endcase
    endtask

    // far from the midpoint on the active channels, near it elsewhere
    function automatic logic [47:0] make_sample(input logic [3:0] active);
        logic [47:0] smp;
        int v;
        for (int c = 0; c < CHANNELS; c++) begin
            if (active[c]) begin
                v = mid_r >= 2048 ? $urandom_range(0, 63) : $urandom_range(4032, 4095);
            end else begin
                v = int'(mid_r) + $urandom_range(0, 32) - 16;
                if (v < 0) v = 0;
                if (v > 4095) v = 4095;
            end
            smp[c*12 +: 12] = 12'(v);
        end
        return smp;
    endfunction

    task automatic step_send(input int dt, input logic [3:0] active);
        now_ms = now_ms + 32'(dt);
        send_sample(make_sample(active), now_ms, 1'b0);
    endtask

    // a run of pulses on some channels, then silence and one quiet sample
    task automatic play_gesture();
        logic [3:0] active;
        int pulses, dt;
        active = 4'($urandom_range(1, 15));
        pulses = $urandom_range(1, 5);
        for (int p = 0; p < pulses; p++) begin
            repeat ($urandom_range(1, 4)) step_send($urandom_range(1, 10), active);
            if ($urandom_range(0, 9) < 8) dt = min_pulse_r + $urandom_range(0, 10);
            else dt = 1;
            if ($urandom_range(0, 9) == 0)
                send_sample(48'({$urandom, $urandom}), $urandom, $urandom_range(0, 1));
            step_send(dt, 4'h0);
            repeat ($urandom_range(0, 2)) step_send($urandom_range(1, silence_r / 4 + 1), 4'h0);
        end
        if ($urandom_range(0, 9) == 0) begin
            now_ms = now_ms + 32'(silence_r) + 1;
            send_sample(make_sample(4'h0), now_ms, 1'b1);
        end
        step_send(silence_r + 1 + $urandom_range(0, 20), 4'h0);
    endtask

    task automatic test_all_channels_report();
        set_reg(CFG_ENV_ALPHA, 24'd65535);
        set_reg(CFG_MIN_PULSE, 24'd0);
        set_reg(CFG_SILENCE, 24'd0);
        set_reg(CFG_LOW_CUTOFF, 24'd127);
        step_send(1, 4'hF);
        step_send(1, 4'h0);
        step_send(1, 4'h0);
        send_sample({12'd0, 12'd4095, 12'd0, 12'd4095}, now_ms + 1, 1'b1);
        drain();
    endtask

    task automatic test_zero_threshold();
        set_reg(CFG_LOW_CUTOFF, 24'd0);
        set_reg(CFG_SILENCE, 24'd100);
        step_send(1, 4'h5);
        step_send(1, 4'h0);
        drain();
        set_reg(CFG_BASE_THR, 24'd0);
        now_ms = now_ms + 200;
        send_sample({4{mid_r}}, now_ms, 1'b0);
        drain();
        set_reg(CFG_BASE_THR, 24'd4095);
        step_send(1, 4'hF);
        step_send(1, 4'h0);
        drain();
    endtask

    task automatic test_long_limits();
        set_reg(CFG_BASE_THR, 24'd1000);
        set_reg(CFG_MIN_PULSE, 24'd65535);
        set_reg(CFG_SILENCE, 24'd65535);
        step_send(1, 4'h3);
        step_send(100, 4'h0);
        step_send(1, 4'h3);
        step_send(65535, 4'h0);
        step_send(65536, 4'h0);
        drain();
    endtask

    task automatic test_wrap_and_adapt();
        set_reg(CFG_MIN_PULSE, 24'd5);
        set_reg(CFG_SILENCE, 24'd10);
        set_reg(CFG_UPD_PERIOD, 24'd1);
        set_reg(CFG_ROLL_WINDOW, 24'd0);
        set_reg(CFG_ADC_MID, 24'd4095);
        now_ms = 32'hFFFF_FFF8;
        step_send(1, 4'hC);
        step_send(6, 4'h0);
        step_send(20, 4'h0);
        drain();
        set_reg(CFG_ROLL_WINDOW, 24'd255);
        set_reg(CFG_ADC_MID, 24'd0);
        set_reg(CFG_UPD_PERIOD, 24'd16777215);
        step_send(3, 4'h9);
        step_send(8, 4'h0);
        now_ms = now_ms + 32'd16777215;
        step_send(1, 4'h0);
        drain();
        set_reg(CFG_ENV_ALPHA, 24'd0);
        step_send(1, 4'hF);
        step_send(1, 4'h0);
        drain();
    endtask

    // a long run of pulses back to back on every channel reports four or more
    task automatic test_long_pulse_run();
        set_reg(CFG_ENV_ALPHA, 24'd65535);
        set_reg(CFG_ADC_MID, 24'd2048);
        set_reg(CFG_MIN_PULSE, 24'd0);
        set_reg(CFG_SILENCE, 24'd60000);
        set_reg(CFG_UPD_PERIOD, 24'd16777215);
        tx_free = 1'b1;
        rx_free = 1'b1;
        repeat (20) begin
            step_send(1, 4'hF);
            step_send(1, 4'h0);
        end
        step_send(60001, 4'h0);
        drain();
        tx_free = 1'b0;
        rx_free = 1'b0;
    endtask

    function automatic logic [23:0] pick_value(input int lo, input int hi, input int typ_lo,
                                               input int typ_hi);
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) return 24'(lo);
        if (roll == 1) return 24'(hi);
        return 24'($urandom_range(typ_lo, typ_hi));
    endfunction

    task automatic test_random_phases();
        int phase_end;
        while (items_sent < 260) begin
            set_reg(CFG_ENV_ALPHA, pick_value(0, 65535, 20000, 65535));
            set_reg(CFG_BASE_THR, pick_value(0, 4095, 300, 2000));
            set_reg(CFG_MIN_PULSE, pick_value(0, 200, 0, 50));
            set_reg(CFG_SILENCE, pick_value(0, 400, 0, 200));
            set_reg(CFG_LOW_CUTOFF, pick_value(0, 127, 0, 110));
            set_reg(CFG_UPD_PERIOD, pick_value(1, 16777215, 1, 500));
            set_reg(CFG_ROLL_WINDOW, pick_value(0, 255, 1, 20));
            set_reg(CFG_ADC_MID, pick_value(0, 4095, 1800, 2300));
            tx_free = $urandom_range(0, 3) == 0;
            rx_free = $urandom_range(0, 3) == 0;
            phase_end = items_sent + $urandom_range(40, 70);
            while (items_sent < phase_end) begin
                if ($urandom_range(0, 9) == 0)
                    send_sample(48'({$urandom, $urandom}), $urandom, $urandom_range(0, 1));
                else
                    play_gesture();
            end
            drain();
        end
    endtask

    // receiver stalls: mostly short, now and then long
    int stall_left = 0;
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (rx_free || $urandom_range(0, 99) < 75) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= 1'b0;
            stall_left <= $urandom_range(0, 19) == 0 ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 2);
        end
    end

    // compare each report with the oldest expectation
    always @(posedge aclk) begin
        gesture_t g;
        if (aresetn && m_tvalid && m_tready) begin
            gestures_seen++;
            if (pending_gestures.size() == 0) begin
                report_mismatch("unexpected report, channel", -1, m_tdata[1:0]);
            end else begin
                g = pending_gestures.pop_front();
                if (m_tdata[1:0] !== g.chan) report_mismatch("channel", g.chan, m_tdata[1:0]);
                if (m_tdata[3:2] !== g.gest) report_mismatch("gesture", g.gest, m_tdata[3:2]);
                if (m_tdata[10:4] !== g.conf)
                    report_mismatch("confidence", g.conf, m_tdata[10:4]);
                if (m_tuser[0] !== g.low) report_mismatch("low flag", g.low, m_tuser[0]);
                if (m_tlast !== g.last) report_mismatch("last", g.last, m_tlast);
                if (m_tdata[15:11] !== 5'd0) report_mismatch("fill", 0, m_tdata[15:11]);
            end
        end
    end

    // end the run when nothing has moved for too long
    int idle_cycles = 0;
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("emg_pulse_gesture_classifier regression: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        reset_predictor();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_all_channels_report();
        test_zero_threshold();
        test_long_limits();
        test_wrap_and_adapt();
        test_long_pulse_run();
        test_random_phases();
        drain();
        if (errors == 0 && pending_gestures.size() == 0) begin
            $display("emg_pulse_gesture_classifier regression: pass");
        end else begin
            $display("emg_pulse_gesture_classifier regression: fail");
        end
        $finish;
    end

endmodule

[emg_pulse_gesture_classifier.f]
+incdir+hdl
hdl/emgc_pkg.sv
hdl/emgc_div.sv
hdl/emg_pulse_gesture_classifier.sv
bench/tb_top.sv
